// ===== design/gbfs_pkg.sv =====
// Shared types, coefficient codes and arithmetic helpers for the beam field sum.
`timescale 1ns / 1ps
package gbfs_pkg;

  localparam int COEFS      = 21;
  localparam int CI_OFF_X   = 0;
  localparam int CI_OFF_Y   = 1;
  localparam int CI_OFF_Z   = 2;
  localparam int CI_ROT     = 3;
  localparam int CI_ISX     = 12;
  localparam int CI_ISY     = 13;
  localparam int CI_PEAK    = 14;
  localparam int CI_K       = 15;
  localparam int CI_PI      = 16;
  localparam int CI_PE      = 17;
  localparam int CI_DIR     = 18;
  localparam int CI_GROUP   = 21;
  localparam int CI_ENABLE  = 22;
  localparam int TERM_CAP   = 1 << 24;

  typedef logic [31:0] word_t;
  typedef logic [COEFS-1:0][31:0] gbfs_coef_t;

  typedef struct packed {
    logic vld;
    logic en;
    logic grp;
    logic last;
  } gbfs_tag_t;

  typedef struct packed {
    gbfs_tag_t       tag;
    word_t           p_i;
    word_t           p_e;
    logic [2:0][31:0] dir;
  } gbfs_side_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } gbfs_state_t;

  function automatic word_t sat32(input logic signed [49:0] v);
    word_t r;
    if (v > 50'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -50'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // floor(a*b/2^16), capped
  function automatic logic [24:0] term_mul(input logic [47:0] a, input word_t b);
    logic [63:0] hi;
    logic [47:0] lo;
    logic [64:0] s;
    logic [24:0] r;
    hi = 64'(a[47:16]) * 64'(b);
    lo = 48'(a[15:0]) * 48'(b);
    s = 65'(hi) + 65'(lo[47:16]);
    if (s > 65'(TERM_CAP)) begin
      r = 25'(TERM_CAP);
    end else begin
      r = s[24:0];
    end
    return r;
  endfunction

endpackage

// ===== design/gbfs_coef_store.sv =====
// Per-laser coefficient memory with enable and group flags, registered read.
`timescale 1ns / 1ps
module gbfs_coef_store #(
  parameter int NUM_LASERS = 8,
  parameter int LW = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [LW-1:0]       wr_laser,
  input  logic [4:0]          wr_coef,
  input  logic [31:0]         wr_data,
  input  gbfs_pkg::gbfs_tag_t rd_tag,
  input  logic [LW-1:0]       rd_addr,
  output gbfs_pkg::gbfs_coef_t coef_r,
  output gbfs_pkg::gbfs_tag_t tag_r
);
  import gbfs_pkg::*;

  word_t mem [COEFS][NUM_LASERS];
  logic [NUM_LASERS-1:0] enable_r;
  logic [NUM_LASERS-1:0] group_r;

  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_coef) < COEFS)) begin
      mem[wr_coef][wr_laser] <= wr_data;
    end
    for (int k = 0; k < COEFS; k++) begin
      coef_r[k] <= mem[k][rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= '0;
      group_r  <= '0;
      tag_r    <= '0;
    end else begin
      if (wr_en && (32'(wr_coef) == CI_GROUP)) begin
        group_r[wr_laser] <= wr_data[0];
      end
      if (wr_en && (32'(wr_coef) == CI_ENABLE)) begin
        enable_r[wr_laser] <= wr_data[0];
      end
      tag_r.vld  <= rd_tag.vld;
      tag_r.last <= rd_tag.last;
      tag_r.en   <= enable_r[rd_addr];
      tag_r.grp  <= group_r[rd_addr];
    end
  end

endmodule

// ===== design/gbfs_exponent.sv =====
// Six-stage pipeline: offset, rotation, squares and the Gaussian exponent q.
`timescale 1ns / 1ps
module gbfs_exponent (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gbfs_pkg::gbfs_tag_t  tag_i,
  input  gbfs_pkg::gbfs_coef_t coef_i,
  input  logic [31:0]          pos_x,
  input  logic [31:0]          pos_y,
  input  logic [31:0]          pos_z,
  input  logic [31:0]          query_time,
  output logic [26:0]          q_r,
  output gbfs_pkg::gbfs_side_t side_o
);
  import gbfs_pkg::*;

  gbfs_tag_t  tg_r [6];
  gbfs_coef_t c_r  [6];

  word_t        v_nxt [3];
  word_t        v_r   [3];
  logic signed [32:0] dt;
  logic [32:0]  adt_nxt, adt_r;
  logic [47:0]  p_nxt [6];
  logic [47:0]  p_r   [6];
  logic [47:0]  t2_nxt, t2_r;
  word_t        r_nxt [2];
  word_t        r_r   [2];
  logic [24:0]  tt_nxt, tt3_r, tt4_r, tt5_r;
  logic [47:0]  x2_nxt, y2_nxt, x2_r, y2_r;
  logic [24:0]  tx_nxt, ty_nxt, tx_r, ty_r;
  logic [26:0]  q_nxt;
  word_t        ar0, ar1;
  logic [63:0]  t2_full, x2_full, y2_full;

  always_comb begin
    v_nxt[0] = sat32(50'($signed(pos_y)) - 50'($signed(coef_i[CI_OFF_Y])));
    v_nxt[1] = sat32(50'($signed(pos_z)) - 50'($signed(coef_i[CI_OFF_Z])));
    v_nxt[2] = sat32(50'($signed(pos_x)) - 50'($signed(coef_i[CI_OFF_X])));
    dt = 33'($signed(query_time)) - 33'($signed(coef_i[CI_PEAK]));
    adt_nxt = dt[32] ? 33'(-dt) : 33'(dt);
  end

  always_comb begin
    logic signed [63:0] pr;
    for (int k = 0; k < 6; k++) begin
      pr = $signed(c_r[0][CI_ROT + k]) * $signed(v_r[k % 3]);
      p_nxt[k] = pr[63:16];
    end
    t2_full = 64'(adt_r) * 64'(adt_r);
    t2_nxt  = t2_full[63:16];
  end

  always_comb begin
    logic signed [49:0] s0, s1;
    s0 = 50'($signed(p_r[0])) + 50'($signed(p_r[1])) + 50'($signed(p_r[2]));
    s1 = 50'($signed(p_r[3])) + 50'($signed(p_r[4])) + 50'($signed(p_r[5]));
    r_nxt[0] = sat32(s0);
    r_nxt[1] = sat32(s1);
    tt_nxt   = term_mul(t2_r, c_r[1][CI_K]);
  end

  always_comb begin
    ar0 = r_r[0][31] ? 32'(-r_r[0]) : r_r[0];
    ar1 = r_r[1][31] ? 32'(-r_r[1]) : r_r[1];
    x2_full = 64'(ar0) * 64'(ar0);
    y2_full = 64'(ar1) * 64'(ar1);
    x2_nxt = x2_full[63:16];
    y2_nxt = y2_full[63:16];
    tx_nxt = term_mul(x2_r, c_r[3][CI_ISX]);
    ty_nxt = term_mul(y2_r, c_r[3][CI_ISY]);
    q_nxt  = 27'({tx_r, 1'b0}) + 27'({ty_r, 1'b0}) + 27'(tt5_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 6; k++) begin
        tg_r[k] <= '0;
      end
    end else begin
      tg_r[0] <= tag_i;
      for (int k = 1; k < 6; k++) begin
        tg_r[k] <= tg_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    c_r[0] <= coef_i;
    for (int k = 1; k < 6; k++) begin
      c_r[k] <= c_r[k-1];
    end
    v_r   <= v_nxt;
    adt_r <= adt_nxt;
    p_r   <= p_nxt;
    t2_r  <= t2_nxt;
    r_r   <= r_nxt;
    tt3_r <= tt_nxt;
    x2_r  <= x2_nxt;
    y2_r  <= y2_nxt;
    tt4_r <= tt3_r;
    tx_r  <= tx_nxt;
    ty_r  <= ty_nxt;
    tt5_r <= tt4_r;
    q_r   <= q_nxt;
  end

  assign side_o.tag    = tg_r[5];
  assign side_o.p_i    = c_r[5][CI_PI];
  assign side_o.p_e    = c_r[5][CI_PE];
  assign side_o.dir[0] = c_r[5][CI_DIR];
  assign side_o.dir[1] = c_r[5][CI_DIR + 1];
  assign side_o.dir[2] = c_r[5][CI_DIR + 2];

endmodule

// ===== design/gbfs_exp_rom.sv =====
// Two-stage exp(-q) lookup for the intensity and field exponents.
`timescale 1ns / 1ps
module gbfs_exp_rom #(
  parameter int DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [26:0]          q_i,
  input  gbfs_pkg::gbfs_side_t side_i,
  output logic [16:0]          e_i_r,
  output logic [16:0]          e_f_r,
  output gbfs_pkg::gbfs_side_t side_r
);
  import gbfs_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic [DEPTH-1:0][16:0] rom_t;

  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] qq;
    logic [64:0] rr;
    qq = '0;
    rr = '0;
    for (int b = 63; b >= 0; b--) begin
      rr = {rr[63:0], n[b]};
      if (rr >= 65'(d)) begin
        rr = rr - 65'(d);
        qq[b] = 1'b1;
      end
    end
    return qq;
  endfunction

  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] h, term, s, cur;
    logic signed [63:0] acc;
    h    = udiv(64'd16 << 30, 64'(DEPTH));
    term = 64'd1 << 30;
    acc  = 64'sd1 << 30;
    for (int n = 1; n <= 24; n++) begin
      term = udiv(term * h, 64'(n) << 30);
      if (n % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    s   = acc[63] ? 64'd0 : 64'(acc);
    cur = 64'd1 << 30;
    for (int i = 0; i < DEPTH; i++) begin
      if (i > 0) begin
        cur = (cur * s + (64'd1 << 29)) >> 30;
      end
      t[i] = 17'((cur + (64'd1 << 13)) >> 14);
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [26:0] q_f;
  logic [32:0] pi_prod, pf_prod;
  logic [IW-1:0] idx_i_nxt, idx_f_nxt, idx_i_r, idx_f_r;
  logic zero_i_r, zero_f_r;
  gbfs_side_t side1_r;
  logic [32:0] sh_i, sh_f;

  always_comb begin
    q_f = q_i >> 1;
    pi_prod = 33'(q_i[19:0]) * 33'(DEPTH);
    pf_prod = 33'(q_f[19:0]) * 33'(DEPTH);
    sh_i = pi_prod >> 20;
    sh_f = pf_prod >> 20;
    idx_i_nxt = sh_i[IW-1:0];
    idx_f_nxt = sh_f[IW-1:0];
  end

  always_ff @(posedge clk) begin
    idx_i_r  <= idx_i_nxt;
    idx_f_r  <= idx_f_nxt;
    zero_i_r <= |q_i[26:20];
    zero_f_r <= |q_f[26:20];
    e_i_r    <= zero_i_r ? 17'd0 : ROM[idx_i_r];
    e_f_r    <= zero_f_r ? 17'd0 : ROM[idx_f_r];
    if (!rst_n) begin
      side1_r <= '0;
      side_r  <= '0;
    end else begin
      side1_r <= side_i;
      side_r  <= side1_r;
    end
  end

endmodule

// ===== design/gbfs_accum.sv =====
// Prefactor and direction products and the saturating per-query sums.
`timescale 1ns / 1ps
module gbfs_accum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  gbfs_pkg::gbfs_side_t side_i,
  input  logic [16:0]          e_i,
  input  logic [16:0]          e_f,
  output logic [47:0]          isum0_r,
  output logic [47:0]          isum1_r,
  output logic [47:0]          fsum_r [3],
  output logic                 sat_r,
  output logic                 done_r
);
  import gbfs_pkg::*;

  localparam logic signed [50:0] SMAX = 51'sd140737488355327;
  localparam logic signed [50:0] SMIN = -51'sd140737488355328;

  gbfs_tag_t tg1_r, tg2_r;
  logic [48:0] ai_full, a_full;
  logic [32:0] ai1_r, a1_r, ai2_r;
  logic [31:0] dir1_r [3];
  logic [49:0] f_r [3];
  logic [49:0] f_nxt [3];

  always_comb begin
    logic signed [65:0] fp;
    ai_full = 49'(side_i.p_i) * 49'(e_i);
    a_full  = 49'(side_i.p_e) * 49'(e_f);
    for (int k = 0; k < 3; k++) begin
      fp = $signed({1'b0, a1_r}) * $signed(dir1_r[k]);
      f_nxt[k] = fp[65:16];
    end
  end

  always_ff @(posedge clk) begin
    ai1_r <= ai_full[48:16];
    a1_r  <= a_full[48:16];
    for (int k = 0; k < 3; k++) begin
      dir1_r[k] <= side_i.dir[k];
    end
    ai2_r <= ai1_r;
    f_r   <= f_nxt;
  end

  always_ff @(posedge clk) begin
    logic [48:0] iu;
    logic signed [50:0] fs;
    logic s;
    if (!rst_n) begin
      tg1_r  <= '0;
      tg2_r  <= '0;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
    end else begin
      tg1_r  <= side_i.tag;
      tg2_r  <= tg1_r;
      done_r <= tg2_r.vld && tg2_r.last;
      if (start) begin
        isum0_r <= '0;
        isum1_r <= '0;
        for (int k = 0; k < 3; k++) begin
          fsum_r[k] <= '0;
        end
        sat_r <= 1'b0;
      end else if (tg2_r.vld && tg2_r.en) begin
        s  = 1'b0;
        iu = 49'(tg2_r.grp ? isum1_r : isum0_r) + 49'(ai2_r);
        if (iu[48]) begin
          iu = {1'b0, {48{1'b1}}};
          s  = 1'b1;
        end
        if (tg2_r.grp) begin
          isum1_r <= iu[47:0];
        end else begin
          isum0_r <= iu[47:0];
          for (int k = 0; k < 3; k++) begin
            fs = 51'($signed(fsum_r[k])) + 51'($signed(f_r[k]));
            if (fs > SMAX) begin
              fs = SMAX;
              s  = 1'b1;
            end else if (fs < SMIN) begin
              fs = SMIN;
              s  = 1'b1;
            end
            fsum_r[k] <= fs[47:0];
          end
        end
        if (s) begin
          sat_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/gaussian_beam_field_sum.sv =====
// Top level: transaction handshakes, laser sequencer, pipeline and result register.
// A load transaction gives no result and leaves the input ready. A query transaction issues
// one laser per cycle from the coefficient memory into a 12-stage pipeline (memory
// read, six exponent stages, two exp table stages, three product and sum stages), so
// no new input transaction is taken until the last laser has left the single pipeline
// and the result is loaded into the output register, where it sits until taken while
// new input is accepted.
`timescale 1ns / 1ps
module gaussian_beam_field_sum #(
  parameter int NUM_LASERS      = 8,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // laser_index, coef_index, coef_value, pos_x, pos_y, pos_z, query_time
  input  logic [167:0] in_tdata,
  // mode
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // intensity_first, intensity_second, field_x, field_y, field_z, saturated
  output logic [247:0] out_tdata
);
  import gbfs_pkg::*;

  localparam int LW = (NUM_LASERS > 1) ? $clog2(NUM_LASERS) : 1;

  gbfs_state_t state_r, state_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [31:0] px_r, py_r, pz_r, qt_r;
  logic in_acc, start, wr_en, load_out, cnt_last;
  logic [31:0] li32;
  gbfs_tag_t issue_tag, st_tag;
  gbfs_coef_t st_coef;
  logic [26:0] q;
  gbfs_side_t side_q, side_e;
  logic [16:0] e_i, e_f;
  logic [47:0] isum0, isum1;
  logic [47:0] fsum [3];
  logic sat, done;
  logic out_valid_r;
  logic [247:0] out_data_r;

  assign in_acc   = in_tvalid && in_tready;
  assign start    = in_acc && in_tuser;
  assign li32     = 32'(in_tdata[2:0]);
  assign wr_en    = in_acc && !in_tuser && (li32 < NUM_LASERS);
  assign cnt_last = (32'(cnt_r) == NUM_LASERS - 1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_ISSUE;
      ST_ISSUE: if (cnt_last) state_nxt = ST_WAIT;
      ST_WAIT:  if (done) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    cnt_nxt   = '0;
    issue_tag = '0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_ISSUE: begin
        issue_tag.vld  = 1'b1;
        issue_tag.last = cnt_last;
        cnt_nxt = cnt_last ? '0 : cnt_r + 1'b1;
      end
      ST_DONE:  load_out = !out_valid_r || out_tready;
      default:  in_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      px_r <= in_tdata[71:40];
      py_r <= in_tdata[103:72];
      pz_r <= in_tdata[135:104];
      qt_r <= in_tdata[167:136];
    end
    if (load_out) begin
      out_data_r <= {7'd0, sat, fsum[2], fsum[1], fsum[0], isum1, isum0};
    end
  end

  gbfs_coef_store #(.NUM_LASERS(NUM_LASERS), .LW(LW)) u_store (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_laser(li32[LW-1:0]),
    .wr_coef(in_tdata[7:3]), .wr_data(in_tdata[39:8]), .rd_tag(issue_tag),
    .rd_addr(cnt_r), .coef_r(st_coef), .tag_r(st_tag)
  );

  gbfs_exponent u_exponent (
    .clk(clk), .rst_n(rst_n), .tag_i(st_tag), .coef_i(st_coef),
    .pos_x(px_r), .pos_y(py_r), .pos_z(pz_r), .query_time(qt_r),
    .q_r(q), .side_o(side_q)
  );

  gbfs_exp_rom #(.DEPTH(EXP_TABLE_DEPTH)) u_exp (
    .clk(clk), .rst_n(rst_n), .q_i(q), .side_i(side_q),
    .e_i_r(e_i), .e_f_r(e_f), .side_r(side_e)
  );

  gbfs_accum u_accum (
    .clk(clk), .rst_n(rst_n), .start(start), .side_i(side_e), .e_i(e_i), .e_f(e_f),
    .isum0_r(isum0), .isum1_r(isum1), .fsum_r(fsum), .sat_r(sat), .done_r(done)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/gbfs_checker.sv =====
// Port-level checks for the beam field sum, bound to the top level.
`timescale 1ns / 1ps
module gbfs_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [247:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input taken during query");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> in_tready)
    else $error("load transaction stalled input");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[247:241] == 7'd0)
    else $error("nonzero result padding");

endmodule

bind gaussian_beam_field_sum gbfs_checker u_gbfs_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
